>>> rtl/plk_pkg.sv
// polyline length accumulator: shared constants and types
// no dependencies; imported by the output interface, the root unit and the top level
`timescale 1ns / 1ps
`default_nettype none

package plk_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int SUM_WIDTH_DEF   = 48;
  localparam int LEN_OUT_W       = 48;
  localparam int CNT_OUT_W       = 32;

  // status of the iterative root unit
  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_sts_t;

endpackage

`default_nettype wire

>>> rtl/plk_if.sv
// valid/ready channels of the polyline length accumulator
// depends on plk_pkg for the result field widths
`timescale 1ns / 1ps
`default_nettype none

interface plk_in_if #(
  parameter int COORD_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

interface plk_out_if
  import plk_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [LEN_OUT_W-1:0] total_length;
  logic [CNT_OUT_W-1:0] vertex_count;

  modport source (output valid, output total_length, output vertex_count, input ready);
  modport sink   (input valid, input total_length, input vertex_count, output ready);
endinterface

`default_nettype wire

>>> rtl/polyline_length_accumulator.sv
// polyline length accumulator top level: sequencer, shared squarer, accumulator
// depends on plk_pkg, plk_if and plk_sqrt
//
//  channel  dir  handshake     payload
//  in_ch    in   valid/ready   point_x, point_y (signed, COORD_WIDTH)
//  out_ch   out  valid/ready   total_length (48), vertex_count (32)
//
// items are worked one at a time: dx and dy are squared in turn on one
// shared multiplier, then the root unit produces one bit per cycle over
// COORD_WIDTH + 1 bits
// in_ch.ready is high only while idle; the result sits in an output register
// and a stalled out_ch only holds the item once its result is ready to load
// synchronous active-low reset clears vertex, length, count and flags
`timescale 1ns / 1ps
`default_nettype none

module polyline_length_accumulator
  import plk_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int SUM_WIDTH   = SUM_WIDTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  plk_in_if.sink     in_ch,
  plk_out_if.source  out_ch
);

  localparam int CW    = COORD_WIDTH;
  localparam int RT_W  = CW + 1;
  localparam int ADD_W = ((SUM_WIDTH > RT_W) ? SUM_WIDTH : RT_W) + 1;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SQX  = 6'b000010,
    ST_SQY  = 6'b000100,
    ST_ADD  = 6'b001000,
    ST_ROOT = 6'b010000,
    ST_ACC  = 6'b100000
  } state_t;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         last_x_r, last_y_r;
  logic                  have_r;
  logic [CW-1:0]         dabs_x_r, dabs_y_r;
  logic [2*CW-1:0]       prod_r, sq_r;
  logic [SUM_WIDTH-1:0]  length_r, length_nxt;
  logic [CNT_OUT_W-1:0]  count_r;
  logic                  out_valid_r;
  logic [LEN_OUT_W-1:0]  out_len_r;
  logic [CNT_OUT_W-1:0]  out_cnt_r;

  logic                  accept;
  logic                  load_out;
  logic signed [CW:0]    dx, dy;
  logic [CW-1:0]         ax, ay;
  logic [CW-1:0]         mul_op;
  logic [2*CW:0]         sq_sum;
  logic [2*RT_W-1:0]     radicand;
  logic [RT_W-1:0]       root;
  sqrt_sts_t             sqrt_sts;
  logic [ADD_W-1:0]      len_sum;
  logic [LEN_OUT_W+SUM_WIDTH-1:0] len_wide;

  assign accept   = in_ch.valid && in_ch.ready;
  assign load_out = (state_r == ST_ACC) && (!out_valid_r || out_ch.ready);

  // absolute coordinate differences to the previous vertex
  assign dx = {in_ch.point_x[CW-1], in_ch.point_x} - {last_x_r[CW-1], last_x_r};
  assign dy = {in_ch.point_y[CW-1], in_ch.point_y} - {last_y_r[CW-1], last_y_r};
  assign ax = dx[CW] ? CW'(-dx) : dx[CW-1:0];
  assign ay = dy[CW] ? CW'(-dy) : dy[CW-1:0];

  // shared squarer
  assign mul_op = (state_r == ST_SQX) ? dabs_x_r : dabs_y_r;

  assign sq_sum   = {1'b0, sq_r} + {1'b0, prod_r};
  assign radicand = {1'b0, sq_sum};

  plk_sqrt #(
    .RT_W (RT_W)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == ST_ADD),
    .radicand (radicand),
    .root     (root),
    .sts      (sqrt_sts)
  );

  // saturating length update
  assign len_sum = ADD_W'(length_r) + ADD_W'(root);
  always_comb begin
    if (len_sum[ADD_W-1:SUM_WIDTH] != '0) begin
      length_nxt = '1;
    end else begin
      length_nxt = len_sum[SUM_WIDTH-1:0];
    end
  end
  assign len_wide = {{LEN_OUT_W{1'b0}}, length_nxt};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) state_nxt = ST_SQX;
      end
      ST_SQX:  state_nxt = ST_SQY;
      ST_SQY:  state_nxt = ST_ADD;
      ST_ADD:  state_nxt = ST_ROOT;
      ST_ROOT: begin
        if (sqrt_sts.done) state_nxt = ST_ACC;
      end
      ST_ACC: begin
        if (load_out) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      last_x_r    <= '0;
      last_y_r    <= '0;
      have_r      <= 1'b0;
      length_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        last_x_r <= in_ch.point_x;
        last_y_r <= in_ch.point_y;
        have_r   <= 1'b1;
        if (count_r != '1) count_r <= count_r + 1'b1;
      end
      if (load_out) begin
        length_r    <= length_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      // first vertex adds nothing
      dabs_x_r <= have_r ? ax : '0;
      dabs_y_r <= have_r ? ay : '0;
    end
    if (state_r == ST_SQX || state_r == ST_SQY) begin
      prod_r <= mul_op * mul_op;
      sq_r   <= prod_r;
    end
    if (load_out) begin
      out_len_r <= len_wide[LEN_OUT_W-1:0];
      out_cnt_r <= count_r;
    end
  end

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.total_length = out_len_r;
  assign out_ch.vertex_count = out_cnt_r;

  a_ready_idle : assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !sqrt_sts.busy)
    else $error("input ready while root unit busy");

  a_done_in_root : assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_sts.done |-> (state_r == ST_ROOT))
    else $error("root result outside root wait");

  a_length_monotonic : assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (length_r >= $past(length_r)))
    else $error("running length decreased");

endmodule

`default_nettype wire

>>> rtl/plk_sqrt.sv
// digit-by-digit integer square root, one root bit per cycle
// depends on plk_pkg for the status struct
`timescale 1ns / 1ps
`default_nettype none

module plk_sqrt
  import plk_pkg::*;
#(
  parameter int RT_W = 25
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [2*RT_W-1:0] radicand,
  output      logic [RT_W-1:0]   root,
  output      sqrt_sts_t         sts
);

  localparam int RAD_W = 2 * RT_W;
  localparam int CNT_W = (RT_W > 1) ? $clog2(RT_W) : 1;
  localparam logic [CNT_W-1:0] LAST_IT = CNT_W'(RT_W - 1);

  logic [RAD_W-1:0] rad_r,  rad_nxt;
  logic [RT_W-1:0]  root_r, root_nxt;
  logic [RT_W+1:0]  rem_r,  rem_nxt;
  logic [CNT_W-1:0] cnt_r,  cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [RT_W+3:0]  rem_sh;
  logic [RT_W+3:0]  trial;
  logic [RT_W+3:0]  diff;

  assign rem_sh = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign diff   = rem_sh - trial;

  always_comb begin
    rad_nxt  = rad_r;
    root_nxt = root_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = radicand;
      root_nxt = '0;
      rem_nxt  = '0;
      cnt_nxt  = LAST_IT;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = diff[RT_W+1:0];
        root_nxt = {root_r[RT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh[RT_W+1:0];
        root_nxt = {root_r[RT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    root_r <= root_nxt;
    rem_r  <= rem_nxt;
  end

  assign root     = root_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

`default_nettype wire

>>> tb/polyline_length_accumulator_test.sv
// self-checking bench for polyline_length_accumulator: random vertices, random stalls,
// results checked against an in-bench running-length predictor
// depends on plk_pkg, plk_if and the accumulator rtl
`timescale 1ns / 1ps

module polyline_length_accumulator_test;
  import plk_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int N_RANDOM = 1500;
  localparam logic [SUM_WIDTH_DEF-1:0] LEN_MAX = '1;
  localparam logic [31:0] CNT_MAX = '1;
  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } vertex_t;

  typedef struct packed {
    logic [LEN_OUT_W-1:0] total_length;
    logic [CNT_OUT_W-1:0] vertex_count;
  } path_result_t;

  logic clk;
  logic rst_n;

  plk_in_if #(.COORD_WIDTH(CW)) in_ch ();
  plk_out_if out_ch ();

  polyline_length_accumulator uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  vertex_t pending_vertices[$];
  path_result_t expected_totals[$];
  int vertices_queued;
  int vertices_taken;
  int mismatch_count;
  bit vertex_taken_flag;

  // predictor state
  logic signed [CW-1:0] prev_x;
  logic signed [CW-1:0] prev_y;
  bit have_prev;
  logic [SUM_WIDTH_DEF-1:0] length_acc;
  logic [31:0] count_acc;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned rem;
    longint unsigned trial;
    root = 0;
    rem = 0;
    for (int i = 31; i >= 0; i--) begin
      rem = (rem << 2) | ((v >> (2 * i)) & 64'd3);
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic path_result_t advance_path(vertex_t v);
    longint dx;
    longint dy;
    longint unsigned sq;
    longint unsigned seg_len;
    path_result_t r;
    if (have_prev) begin
      dx = longint'(v.x) - longint'(prev_x);
      dy = longint'(v.y) - longint'(prev_y);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      sq = longint'(dx * dx) + longint'(dy * dy);
      seg_len = floor_sqrt(sq);
      if (seg_len > longint'(LEN_MAX - length_acc)) length_acc = LEN_MAX;
      else length_acc = length_acc + seg_len[SUM_WIDTH_DEF-1:0];
    end
    prev_x = v.x;
    prev_y = v.y;
    have_prev = 1'b1;
    if (count_acc != CNT_MAX) count_acc = count_acc + 32'd1;
    r.total_length = length_acc[LEN_OUT_W-1:0];
    r.vertex_count = count_acc;
    return r;
  endfunction

  function automatic bit quiet_window();
    return vertices_taken >= 700 && vertices_taken < 1000;
  endfunction

  // driver: next vertex offered at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= quiet_window() || ($urandom_range(99) >= 32);
      if (!in_ch.valid || vertex_taken_flag) begin
        vertex_taken_flag = 1'b0;
        if (pending_vertices.size() != 0 && (quiet_window() || $urandom_range(99) >= 32)) begin
          in_ch.valid <= 1'b1;
          {in_ch.point_x, in_ch.point_y} <= pending_vertices.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: accepted vertices feed the predictor, results checked in order
  always @(posedge clk) begin : monitor_side
    vertex_t v;
    path_result_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        v.x = in_ch.point_x;
        v.y = in_ch.point_y;
        expected_totals = {expected_totals, advance_path(v)};
        vertices_taken++;
        vertex_taken_flag = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_totals.size() == 0) begin
          $error("unexpected result: total_length %0d vertex_count %0d",
                 out_ch.total_length, out_ch.vertex_count);
          mismatch_count++;
        end else begin
          want = expected_totals.pop_front();
          if (out_ch.total_length !== want.total_length) begin
            $error("total_length: expected %0d, actual %0d",
                   want.total_length, out_ch.total_length);
            mismatch_count++;
          end
          if (out_ch.vertex_count !== want.vertex_count) begin
            $error("vertex_count: expected %0d, actual %0d",
                   want.vertex_count, out_ch.vertex_count);
            mismatch_count++;
          end
        end
      end
    end
  end

  function automatic void queue_vertex(logic signed [CW-1:0] x, logic signed [CW-1:0] y);
    vertex_t v;
    v.x = x;
    v.y = y;
    pending_vertices = {pending_vertices, v};
    vertices_queued++;
  endfunction

  initial begin
    vertex_t last;
    logic signed [CW:0] step;
    int shift;
    int pick;
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    out_ch.ready = 1'b0;
    vertex_taken_flag = 1'b0;
    vertices_queued = 0;
    vertices_taken = 0;
    mismatch_count = 0;
    have_prev = 1'b0;
    prev_x = '0;
    prev_y = '0;
    length_acc = '0;
    count_acc = '0;

    // first vertex, repeats, corners, exact and inexact distances
    queue_vertex('0, '0);
    queue_vertex('0, '0);
    queue_vertex(C_MAX, C_MAX);
    queue_vertex(C_MIN, C_MIN);
    queue_vertex(C_MAX, C_MIN);
    queue_vertex(C_MIN, C_MAX);
    queue_vertex(C_MIN, C_MAX);
    queue_vertex('0, '0);
    queue_vertex(24'sd12288, 24'sd16384);
    queue_vertex(24'sd1, 24'sd0);
    queue_vertex(24'sd1, 24'sd0);
    queue_vertex(-24'sd1, -24'sd1);
    queue_vertex(24'sd2, -24'sd3);
    queue_vertex(24'sh555555, 24'shAAAAAA);
    queue_vertex(24'shAAAAAA, 24'sh555555);
    queue_vertex(C_MIN, '0);
    queue_vertex('0, C_MAX);
    queue_vertex(C_MAX, '0);
    queue_vertex('0, C_MIN);
    queue_vertex(-24'sd4096, 24'sd4096);

    last = pending_vertices[$];
    for (int i = 0; i < N_RANDOM; i++) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        last.x = CW'($urandom);
        last.y = CW'($urandom);
      end else if (pick < 80) begin
        shift = $urandom_range(16);
        step = (CW+1)'($signed(($urandom & ((32'd1 << (shift + 1)) - 1)))
                       - (33'sd1 <<< shift));
        last.x = last.x + step[CW-1:0];
        step = (CW+1)'($signed(($urandom & ((32'd1 << (shift + 1)) - 1)))
                       - (33'sd1 <<< shift));
        last.y = last.y + step[CW-1:0];
      end else if (pick < 90) begin
        // repeated vertex
      end else begin
        last.x = $urandom_range(1) ? C_MAX : C_MIN;
        last.y = $urandom_range(1) ? C_MAX : C_MIN;
        if ($urandom_range(1)) last.y = CW'($urandom);
      end
      queue_vertex(last.x, last.y);
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (vertices_taken < vertices_queued) @(posedge clk);
    while (expected_totals.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    if (expected_totals.size() != 0) begin
      $error("%0d results never arrived", expected_totals.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("polyline_length_accumulator_test: done, clean");
    end else begin
      $display("polyline_length_accumulator_test: done, errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $error("timeout");
    $display("polyline_length_accumulator_test: done, errors");
    $finish;
  end

endmodule

>>> files.f
rtl/plk_pkg.sv
rtl/plk_if.sv
rtl/plk_sqrt.sv
rtl/polyline_length_accumulator.sv
tb/polyline_length_accumulator_test.sv
